// File: src/nec_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// nec_pkg
// Shared types, register indexes and window math for the NEC IR edge decoder.
// ============================================================================
package nec_pkg;

    // Frame and register file geometry
    localparam int FRAME_BITS      = 32;
    localparam int REG_COUNT       = 8;
    localparam int REG_IDX_W       = $clog2(REG_COUNT);
    localparam int CFG_INDEX_W     = REG_IDX_W + 1;
    localparam int NOM_W           = 17;
    localparam int HI_W            = NOM_W + 1;
    localparam int TIMEOUT_W       = 18;
    localparam int ELAPSED_W       = 20;
    localparam int MUL_W           = 9;
    localparam int PROD_W          = NOM_W + MUL_W;
    localparam int TOLERANCE_FRAC_DEF = 64;

    // Register indexes
    localparam logic [REG_IDX_W-1:0] REG_LEADER_LOW    = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_LEADER_HIGH   = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_HIGH   = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_LOW    = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_REPEAT_PERIOD = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_BIT_LOW       = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_BIT_ONE_HIGH  = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_BIT_ZERO_HIGH = 3'd7;

    // Reset values of the timing registers, in microseconds
    localparam logic [NOM_W-1:0] REG_RESET [REG_COUNT] = '{
        17'd9000, 17'd4500, 17'd2250, 17'd560,
        17'd108000, 17'd560, 17'd1690, 17'd560
    };

    // One input edge transaction
    typedef struct packed {
        logic                 edge_req;
        logic [ELAPSED_W-1:0] interval_us;
    } nec_in_t;

    // One result transaction
    typedef struct packed {
        logic [TIMEOUT_W-1:0] timeout_us;
        logic                 frame_valid;
        logic [7:0]           address;
        logic [7:0]           command;
        logic                 repeat_seen;
        logic [7:0]           repeat_count;
    } nec_out_t;

    // Nominal width and its open acceptance window
    typedef struct packed {
        logic [NOM_W-1:0] nom;
        logic [NOM_W-1:0] lo;
        logic [HI_W-1:0]  hi;
    } nec_win_t;

    // Lower window bound: floor(n * m / 256), never above n
    function automatic logic [NOM_W-1:0] win_lo(logic [NOM_W-1:0] n, logic [MUL_W-1:0] m);
        logic [PROD_W-1:0] p;
        p = PROD_W'(n) * PROD_W'(m);
        return p[PROD_W-2:8];
    endfunction

    // Upper window bound: floor(n * m / 256), never above 2n
    function automatic logic [HI_W-1:0] win_hi(logic [NOM_W-1:0] n, logic [MUL_W-1:0] m);
        logic [PROD_W-1:0] p;
        p = PROD_W'(n) * PROD_W'(m);
        return p[PROD_W-1:8];
    endfunction

endpackage

// File: src/nec_ir_edge_decoder.sv
`timescale 1ns / 1ps
// Path: input register, then result register, from input transaction to result.
// Throughput: one edge per cycle unless the result stalls; the decode step updates state.
// Reset: asynchronous active low; timing registers return to their defaults, the
// decoder returns to idle and the latched bytes and repeat count clear.
// ============================================================================
// nec_ir_edge_decoder
// NEC infrared frame decoder driven by edge events. Walks idle, leader,
// repeat and data phases, checks the complemented bytes and counts repeats.
// ============================================================================
module nec_ir_edge_decoder
    import nec_pkg::*;
#(
    parameter int TOLERANCE_FRAC = TOLERANCE_FRAC_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  nec_in_t                in_data,
    output logic                   out_valid,
    input  logic                   out_ready,
    output nec_out_t               out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [NOM_W-1:0]       cfg_data
);

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_LEADER,
        PH_REPEAT,
        PH_DATA
    } phase_t;

    localparam int BITS_W = $clog2(FRAME_BITS) + 1;
    localparam int SHIFT_W = $clog2(FRAME_BITS);

    nec_win_t [REG_COUNT-1:0] win;

    logic                 s1_valid_reg;
    nec_in_t              s1_item_reg;
    logic                 out_valid_reg;
    nec_out_t             out_data_reg;

    phase_t               phase_reg,  phase_next;
    logic [BITS_W-1:0]    bits_reg,   bits_next;
    logic [FRAME_BITS-1:0] word_reg,  word_next;
    logic [7:0]           addr_reg,   addr_next;
    logic [7:0]           cmd_reg,    cmd_next;
    logic [7:0]           rep_reg,    rep_next;

    logic                 step_fire;
    logic [REG_COUNT-1:0] match;
    logic                 bit_val;
    logic [FRAME_BITS-1:0] word_shift;
    logic [BITS_W-1:0]    bits_inc;
    logic [TIMEOUT_W-1:0] timeout_next;
    logic                 frame_ok_next;
    logic                 rep_seen_next;
    nec_win_t             tmo_win;
    logic                 tmo_en;

    // Configuration register file
    assign cfg_ready = 1'b1;

    nec_cfg #(
        .TOLERANCE_FRAC (TOLERANCE_FRAC)
    ) u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .win      (win)
    );

    // Advance the decode step when the result register is free
    assign step_fire = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || step_fire;

    // Capture the next edge transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_item_reg <= in_data;
        end
    end

    // Compare the edge width against every acceptance window
    always_comb
    begin
        for (int i = 0; i < REG_COUNT; i++)
        begin
            match[i] = (s1_item_reg.interval_us > ELAPSED_W'(win[i].lo)) &&
                       (s1_item_reg.interval_us < ELAPSED_W'(win[i].hi));
        end
    end

    assign bit_val    = match[REG_BIT_ONE_HIGH];
    assign word_shift = word_reg | (FRAME_BITS'(bit_val) << bits_reg[SHIFT_W-1:0]);
    assign bits_inc   = bits_reg + BITS_W'(1);

    // Decode step: next state and result fields
    always_comb
    begin
        phase_next    = phase_reg;
        bits_next     = bits_reg;
        word_next     = word_reg;
        addr_next     = addr_reg;
        cmd_next      = cmd_reg;
        rep_next      = rep_reg;
        frame_ok_next = 1'b0;
        rep_seen_next = 1'b0;
        tmo_en        = 1'b0;
        tmo_win       = win[REG_BIT_LOW];

        case (phase_reg)
            PH_IDLE:
            begin
                if (s1_item_reg.edge_req && match[REG_LEADER_LOW])
                begin
                    phase_next = PH_LEADER;
                    tmo_en     = 1'b1;
                    tmo_win    = win[REG_LEADER_HIGH];
                end
            end
            PH_LEADER:
            begin
                if (!s1_item_reg.edge_req && match[REG_LEADER_HIGH])
                begin
                    phase_next = PH_DATA;
                    bits_next  = '0;
                    word_next  = '0;
                    tmo_en     = 1'b1;
                    tmo_win    = win[REG_BIT_LOW];
                end
                else if (!s1_item_reg.edge_req && match[REG_REPEAT_HIGH])
                begin
                    phase_next = PH_REPEAT;
                    tmo_en     = 1'b1;
                    tmo_win    = win[REG_REPEAT_LOW];
                end
                else
                begin
                    phase_next = PH_IDLE;
                    bits_next  = '0;
                    word_next  = '0;
                end
            end
            PH_REPEAT:
            begin
                // Any edge ends the repeat code; only a matching tail counts
                if (s1_item_reg.edge_req && match[REG_REPEAT_LOW])
                begin
                    if (rep_reg != 8'hFF)
                    begin
                        rep_next = rep_reg + 8'd1;
                    end
                    rep_seen_next = 1'b1;
                    tmo_en        = 1'b1;
                    tmo_win       = win[REG_REPEAT_PERIOD];
                end
                phase_next = PH_IDLE;
                bits_next  = '0;
                word_next  = '0;
            end
            PH_DATA:
            begin
                if (s1_item_reg.edge_req)
                begin
                    if (match[REG_BIT_LOW])
                    begin
                        tmo_en  = 1'b1;
                        tmo_win = win[REG_BIT_ONE_HIGH];
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        bits_next  = '0;
                        word_next  = '0;
                    end
                end
                else if (match[REG_BIT_ONE_HIGH] || match[REG_BIT_ZERO_HIGH])
                begin
                    if (bits_inc == BITS_W'(FRAME_BITS))
                    begin
                        // Frame complete: latch only if both bytes check
                        if ((word_shift[7:0] == ~word_shift[15:8]) &&
                            (word_shift[23:16] == ~word_shift[31:24]))
                        begin
                            addr_next     = word_shift[7:0];
                            cmd_next      = word_shift[23:16];
                            rep_next      = '0;
                            frame_ok_next = 1'b1;
                        end
                        phase_next = PH_IDLE;
                        bits_next  = '0;
                        word_next  = '0;
                    end
                    else
                    begin
                        bits_next = bits_inc;
                        word_next = word_shift;
                        tmo_en    = 1'b1;
                        tmo_win   = win[REG_BIT_LOW];
                    end
                end
                else
                begin
                    phase_next = PH_IDLE;
                    bits_next  = '0;
                    word_next  = '0;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
                bits_next  = '0;
                word_next  = '0;
            end
        endcase

        // Timeout is 1.5 times the expected width
        timeout_next = tmo_en ?
            (TIMEOUT_W'(tmo_win.nom) + TIMEOUT_W'(tmo_win.nom >> 1)) : '0;
    end

    // Hold decoder state and the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bits_reg      <= '0;
            word_reg      <= '0;
            addr_reg      <= '0;
            cmd_reg       <= '0;
            rep_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            if (step_fire)
            begin
                phase_reg                 <= phase_next;
                bits_reg                  <= bits_next;
                word_reg                  <= word_next;
                addr_reg                  <= addr_next;
                cmd_reg                   <= cmd_next;
                rep_reg                   <= rep_next;
                out_valid_reg             <= 1'b1;
                out_data_reg.timeout_us   <= timeout_next;
                out_data_reg.frame_valid  <= frame_ok_next;
                out_data_reg.address      <= addr_next;
                out_data_reg.command      <= cmd_next;
                out_data_reg.repeat_seen  <= rep_seen_next;
                out_data_reg.repeat_count <= rep_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: src/nec_cfg.sv
`timescale 1ns / 1ps
// ============================================================================
// nec_cfg
// Timing register file. Each write also stores the precomputed acceptance
// window of the written width, so the decode path only compares.
// ============================================================================
module nec_cfg
    import nec_pkg::*;
#(
    parameter int TOLERANCE_FRAC = TOLERANCE_FRAC_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [NOM_W-1:0]       wr_data,
    output nec_win_t [REG_COUNT-1:0] win
);

    localparam logic [MUL_W-1:0] LO_MUL = MUL_W'(256 - TOLERANCE_FRAC);
    localparam logic [MUL_W-1:0] HI_MUL = MUL_W'(256 + TOLERANCE_FRAC);

    nec_win_t [REG_COUNT-1:0] win_reg;
    nec_win_t                 win_next;

    // Window of the incoming write data
    always_comb
    begin
        win_next.nom = wr_data;
        win_next.lo  = win_lo(wr_data, LO_MUL);
        win_next.hi  = win_hi(wr_data, HI_MUL);
    end

    // Hold registers; drop writes beyond the register list
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < REG_COUNT; i++)
            begin
                win_reg[i].nom <= REG_RESET[i];
                win_reg[i].lo  <= win_lo(REG_RESET[i], LO_MUL);
                win_reg[i].hi  <= win_hi(REG_RESET[i], HI_MUL);
            end
        end
        else if (wr_en && (wr_index < CFG_INDEX_W'(REG_COUNT)))
        begin
            win_reg[wr_index[REG_IDX_W-1:0]] <= win_next;
        end
    end

    assign win = win_reg;

endmodule

// File: sim/nec_ir_edge_decoder_test.sv
`timescale 1ns / 1ps
// ============================================================================
// nec_ir_edge_decoder_test
// Self-checking bench for the NEC IR edge decoder. A behavioral decoder runs
// beside the block and predicts each result transaction from the accepted
// edges. Named tests cover directed corner edges, repeat count saturation,
// mixed frame traffic under backpressure and a sweep of the timing registers.
// ============================================================================
module nec_ir_edge_decoder_test;
    import nec_pkg::*;

    localparam int TOL          = TOLERANCE_FRAC_DEF;
    localparam int ELAPSED_MAX  = (1 << ELAPSED_W) - 1;
    localparam int NOM_MAX      = (1 << NOM_W) - 1;
    localparam int DRAIN_CYCLES = 4;

    typedef enum logic [1:0] {DEC_IDLE, DEC_LEADER, DEC_REPEAT, DEC_DATA} dec_phase_t;
    typedef enum int {RECV_ALWAYS, RECV_RANDOM, RECV_PATTERN} recv_mode_t;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_ready;
    nec_in_t                in_data;
    logic                   out_valid;
    logic                   out_ready;
    nec_out_t               out_data;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [NOM_W-1:0]       cfg_data;

    // Decoder shadow state and register copy
    dec_phase_t       dec_phase;
    logic [5:0]       dec_bits;
    logic [31:0]      dec_word;
    logic [7:0]       dec_address;
    logic [7:0]       dec_command;
    logic [7:0]       dec_repeats;
    logic [NOM_W-1:0] timing_regs [REG_COUNT];

    nec_out_t   pending_results [$];
    int         fail_count;
    int         edges_sent;
    int         burst_left;
    bit         sender_idle;
    recv_mode_t recv_mode;
    int         hold_req;

    nec_ir_edge_decoder u_top
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Open window test: strictly between floor(n*(256-T)/256) and floor(n*(256+T)/256)
    function automatic bit in_window(input logic [ELAPSED_W-1:0] v, input logic [NOM_W-1:0] nom);
        longint lo;
        longint hi;
        lo = (longint'(nom) * (256 - TOL)) >> 8;
        hi = (longint'(nom) * (256 + TOL)) >> 8;
        return (longint'(v) > lo) && (longint'(v) < hi);
    endfunction

    // Timeout is one and a half times the expected width
    function automatic logic [TIMEOUT_W-1:0] timeout_for(input logic [NOM_W-1:0] nom);
        logic [TIMEOUT_W-1:0] w;
        w = TIMEOUT_W'(nom);
        return w + (w >> 1);
    endfunction

    function automatic void decoder_restart();
        dec_phase = DEC_IDLE;
        dec_bits  = '0;
        dec_word  = '0;
    endfunction

    // Advance the shadow decoder by one edge and return the result it gives
    function automatic nec_out_t decode_edge(input nec_in_t item);
        nec_out_t             res;
        logic                 rising;
        logic [ELAPSED_W-1:0] t;
        logic                 bit_val;
        bit                   bit_ok;
        res     = '0;
        rising  = item.edge_req;
        t       = item.interval_us;
        bit_val = 1'b0;
        bit_ok  = 1'b0;
        case (dec_phase)
            DEC_IDLE:
            begin
                if (rising && in_window(t, timing_regs[REG_LEADER_LOW]))
                begin
                    dec_phase      = DEC_LEADER;
                    res.timeout_us = timeout_for(timing_regs[REG_LEADER_HIGH]);
                end
            end
            DEC_LEADER:
            begin
                // Data frame space wins over repeat space
                if (!rising && in_window(t, timing_regs[REG_LEADER_HIGH]))
                begin
                    dec_phase      = DEC_DATA;
                    dec_bits       = '0;
                    dec_word       = '0;
                    res.timeout_us = timeout_for(timing_regs[REG_BIT_LOW]);
                end
                else if (!rising && in_window(t, timing_regs[REG_REPEAT_HIGH]))
                begin
                    dec_phase      = DEC_REPEAT;
                    res.timeout_us = timeout_for(timing_regs[REG_REPEAT_LOW]);
                end
                else
                begin
                    decoder_restart();
                end
            end
            DEC_REPEAT:
            begin
                if (rising && in_window(t, timing_regs[REG_REPEAT_LOW]))
                begin
                    if (dec_repeats != 8'hFF)
                        dec_repeats = dec_repeats + 8'd1;
                    res.repeat_seen = 1'b1;
                    res.timeout_us  = timeout_for(timing_regs[REG_REPEAT_PERIOD]);
                end
                decoder_restart();
            end
            default:
            begin
                if (rising)
                begin
                    if (in_window(t, timing_regs[REG_BIT_LOW]))
                        res.timeout_us = timeout_for(timing_regs[REG_BIT_ONE_HIGH]);
                    else
                        decoder_restart();
                end
                else
                begin
                    // Ones are tested before zeros
                    if (in_window(t, timing_regs[REG_BIT_ONE_HIGH]))
                    begin
                        bit_val = 1'b1;
                        bit_ok  = 1'b1;
                    end
                    else if (in_window(t, timing_regs[REG_BIT_ZERO_HIGH]))
                    begin
                        bit_ok = 1'b1;
                    end
                    if (!bit_ok)
                    begin
                        decoder_restart();
                    end
                    else
                    begin
                        dec_word[dec_bits[4:0]] = bit_val;
                        dec_bits = dec_bits + 6'd1;
                        if (dec_bits >= 6'(FRAME_BITS))
                        begin
                            if (dec_word[7:0] == ~dec_word[15:8] &&
                                dec_word[23:16] == ~dec_word[31:24])
                            begin
                                dec_address     = dec_word[7:0];
                                dec_command     = dec_word[23:16];
                                dec_repeats     = '0;
                                res.frame_valid = 1'b1;
                            end
                            decoder_restart();
                        end
                        else
                        begin
                            res.timeout_us = timeout_for(timing_regs[REG_BIT_LOW]);
                        end
                    end
                end
            end
        endcase
        res.address      = dec_address;
        res.command      = dec_command;
        res.repeat_count = dec_repeats;
        return res;
    endfunction

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned act_val);
        if (exp_val != act_val)
        begin
            $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
            fail_count++;
        end
    endfunction

    // Check each result transaction against the oldest prediction
    initial
    begin
        nec_out_t exp_res;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    $error("result transaction with no prediction waiting");
                    fail_count++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    check_field("timeout_us", 32'(exp_res.timeout_us),
                                32'(out_data.timeout_us));
                    check_field("frame_valid", 32'(exp_res.frame_valid),
                                32'(out_data.frame_valid));
                    check_field("address", 32'(exp_res.address), 32'(out_data.address));
                    check_field("command", 32'(exp_res.command), 32'(out_data.command));
                    check_field("repeat_seen", 32'(exp_res.repeat_seen),
                                32'(out_data.repeat_seen));
                    check_field("repeat_count", 32'(exp_res.repeat_count),
                                32'(out_data.repeat_count));
                end
            end
        end
    end

    // Receiver: long hold-off on request, otherwise stall per mode
    initial
    begin
        int unsigned cyc;
        int          hold_left;
        logic [15:0] pattern;
        cyc       = 0;
        hold_left = 0;
        pattern   = 16'b1101_1110_0110_1011;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            cyc++;
            if (hold_req > 0)
            begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready = 1'b0;
            end
            else
            begin
                case (recv_mode)
                    RECV_ALWAYS:  out_ready = 1'b1;
                    RECV_RANDOM:  out_ready = ($urandom_range(0, 9) < 7);
                    default:      out_ready = pattern[cyc % 16];
                endcase
            end
        end
    end

    // Send one edge transaction; entered and left at a falling edge
    task automatic send_edge(input logic pol, input int unsigned us);
        nec_in_t item;
        int      gap;
        item.edge_req    = pol;
        item.interval_us = ELAPSED_W'(us);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap = (sender_idle && $urandom_range(0, 3) != 0) ? $urandom_range(1, 5) : 0;
            repeat (gap) @(negedge clk);
        end
        burst_left--;
        in_data  = item;
        in_valid = 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(decode_edge(item));
        edges_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    // Width near the nominal value, mostly inside the window, sometimes at its rim
    function automatic int unsigned pick_width(input logic [NOM_W-1:0] nom);
        int lo;
        int hi;
        int r;
        lo = (int'(nom) * (256 - TOL)) >> 8;
        hi = (int'(nom) * (256 + TOL)) >> 8;
        if (hi <= lo + 1)
            return $urandom_range(0, 2 * int'(nom) + 2);
        r = $urandom_range(0, 9);
        if (r == 0)
            return lo + 1;
        if (r == 1)
            return hi - 1;
        return $urandom_range(lo + 1, hi - 1);
    endfunction

    // Send a mark or space; rarely corrupt its width
    task automatic send_mark(input logic pol, input logic [NOM_W-1:0] nom);
        int unsigned us;
        us = pick_width(nom);
        if ($urandom_range(0, 199) == 0)
            us = $urandom_range(0, ELAPSED_MAX);
        send_edge(pol, us);
    endtask

    task automatic send_frame(input logic [7:0] addr, input logic [7:0] cmd,
                              input bit break_check);
        logic [31:0] word;
        word = {~cmd, cmd, ~addr, addr};
        if (break_check)
            word[$urandom_range(0, 31)] ^= 1'b1;
        send_mark(1'b1, timing_regs[REG_LEADER_LOW]);
        send_mark(1'b0, timing_regs[REG_LEADER_HIGH]);
        for (int i = 0; i < FRAME_BITS; i++)
        begin
            send_mark(1'b1, timing_regs[REG_BIT_LOW]);
            send_mark(1'b0, word[i] ? timing_regs[REG_BIT_ONE_HIGH]
                                    : timing_regs[REG_BIT_ZERO_HIGH]);
        end
    endtask

    task automatic send_repeat_code();
        send_mark(1'b1, timing_regs[REG_LEADER_LOW]);
        send_mark(1'b0, timing_regs[REG_REPEAT_HIGH]);
        send_mark(1'b1, timing_regs[REG_REPEAT_LOW]);
    endtask

    // Stray edge: full range, near a register, on a window rim, or tiny
    task automatic send_noise();
        int          r;
        int          lo;
        int          hi;
        logic [NOM_W-1:0] nom;
        r   = $urandom_range(0, 3);
        nom = timing_regs[$urandom_range(0, REG_COUNT - 1)];
        lo  = (int'(nom) * (256 - TOL)) >> 8;
        hi  = (int'(nom) * (256 + TOL)) >> 8;
        case (r)
            0: send_edge(1'($urandom_range(0, 1)), $urandom_range(0, ELAPSED_MAX));
            1: send_edge(1'($urandom_range(0, 1)), pick_width(nom));
            2: send_edge(1'($urandom_range(0, 1)), $urandom_range(0, 1) ? lo : hi);
            default: send_edge(1'($urandom_range(0, 1)), $urandom_range(0, 3));
        endcase
    endtask

    // Mostly well-formed frames and repeat codes, some broken ones and noise
    task automatic run_traffic(input int target);
        int start;
        int r;
        start = edges_sent;
        while (edges_sent - start < target)
        begin
            r = $urandom_range(0, 99);
            if (r < 50)
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           $urandom_range(0, 4) == 0);
            else if (r < 80)
                send_repeat_code();
            else
                repeat ($urandom_range(1, 4)) send_noise();
        end
    endtask

    // Wait until every predicted result has come back, then let the pipe settle
    task automatic wait_idle();
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input int idx, input int unsigned val);
        cfg_index = CFG_INDEX_W'(idx);
        cfg_data  = NOM_W'(val);
        cfg_valid = 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        if (idx < REG_COUNT)
            timing_regs[idx] = NOM_W'(val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Corner edges with the reset timing
    task automatic test_directed_edges();
        recv_mode   = RECV_ALWAYS;
        sender_idle = 1'b0;
        // Idle: falling edge, too wide, both window rims, then just inside
        send_edge(1'b0, 0);
        send_edge(1'b1, ELAPSED_MAX);
        send_edge(1'b1, 6750);
        send_edge(1'b1, 11250);
        send_edge(1'b1, 6751);
        // Leader: rising edge restarts
        send_edge(1'b1, 4500);
        // Leader: falling edge of no known width restarts
        send_edge(1'b1, 11249);
        send_edge(1'b0, 0);
        // Valid repeat code
        send_edge(1'b1, 9000);
        send_edge(1'b0, 2250);
        send_edge(1'b1, 560);
        // Repeat phase: falling edge, then wrong tail width
        send_edge(1'b1, 9000);
        send_edge(1'b0, 2250);
        send_edge(1'b0, 560);
        send_edge(1'b1, 9000);
        send_edge(1'b0, 2250);
        send_edge(1'b1, 700);
        // Data phase: a one, a zero, then a bad mark
        send_edge(1'b1, 9000);
        send_edge(1'b0, 4500);
        send_edge(1'b1, 560);
        send_edge(1'b0, 1690);
        send_edge(1'b1, 421);
        send_edge(1'b0, 560);
        send_edge(1'b1, 100);
        // Data phase: bad space
        send_edge(1'b1, 9000);
        send_edge(1'b0, 3376);
        send_edge(1'b1, 699);
        send_edge(1'b0, 2112);
        wait_idle();
    endtask

    // Enough repeat codes to saturate the count, then a frame to clear it
    task automatic test_repeat_saturation();
        recv_mode   = RECV_PATTERN;
        sender_idle = 1'b1;
        for (int i = 0; i < 268; i++)
        begin
            send_repeat_code();
            if ($urandom_range(0, 19) == 0)
                send_noise();
        end
        send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), 1'b0);
        wait_idle();
    endtask

    // Mixed traffic; the receiver first holds off long so the block backs up
    task automatic test_frame_traffic();
        recv_mode   = RECV_RANDOM;
        sender_idle = 1'b0;
        hold_req    = 400;
        run_traffic(110);
        sender_idle = 1'b1;
        run_traffic(110);
        wait_idle();
    endtask

    // Walk the timing registers through random, extreme and overlapping settings
    task automatic test_register_sweep();
        recv_mode   = RECV_PATTERN;
        sender_idle = 1'b1;
        for (int i = 0; i < REG_COUNT; i++)
            write_reg(i, $urandom_range(200, 30000));
        run_traffic(50);
        wait_idle();

        for (int i = 0; i < REG_COUNT; i++)
            write_reg(i, NOM_MAX);
        run_traffic(50);
        wait_idle();

        // Equal spaces: data frame wins over repeat, ones win over zeros
        recv_mode = RECV_RANDOM;
        write_reg(REG_LEADER_LOW, 4);
        write_reg(REG_LEADER_HIGH, 2000);
        write_reg(REG_REPEAT_HIGH, 2000);
        write_reg(REG_REPEAT_LOW, 1);
        write_reg(REG_REPEAT_PERIOD, 0);
        write_reg(REG_BIT_LOW, 4);
        write_reg(REG_BIT_ONE_HIGH, 100);
        write_reg(REG_BIT_ZERO_HIGH, 100);
        run_traffic(50);
        wait_idle();

        // All zero: no width can match
        for (int i = 0; i < REG_COUNT; i++)
            write_reg(i, 0);
        repeat (30) send_noise();
        wait_idle();

        // Back to reset timing; writes past the last register must be dropped
        recv_mode = RECV_ALWAYS;
        for (int i = 0; i < REG_COUNT; i++)
            write_reg(i, REG_RESET[i]);
        for (int i = REG_COUNT; i < (1 << CFG_INDEX_W); i++)
            write_reg(i, $urandom_range(0, NOM_MAX));
        run_traffic(50);
        wait_idle();
    endtask

    // Run limit
    initial
    begin
        #3_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Test sequence
    initial
    begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        fail_count  = 0;
        edges_sent  = 0;
        burst_left  = 0;
        sender_idle = 1'b0;
        recv_mode   = RECV_ALWAYS;
        hold_req    = 0;
        for (int i = 0; i < REG_COUNT; i++)
            timing_regs[i] = REG_RESET[i];
        dec_address = '0;
        dec_command = '0;
        dec_repeats = '0;
        decoder_restart();

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        repeat (2) @(negedge clk);

        test_directed_edges();
        test_repeat_saturation();
        test_frame_traffic();
        test_register_sweep();

        wait_idle();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
